>>> rtl/nft_pkg.sv
`default_nettype none

package nft_pkg;

   // Widths of the request and result fields.
   localparam int OP_W     = 2;
   localparam int ADDR_W   = 32;
   localparam int PORT_W   = 16;
   localparam int KEY_W    = ADDR_W + PORT_W;
   localparam int DEST_W   = 32;
   localparam int STATUS_W = 2;

   // Packed stream widths, padded to whole bytes.
   localparam int REQ_BITS = OP_W + ADDR_W + PORT_W + DEST_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = 1 + DEST_W + STATUS_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_UPDATED  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DONE     = 2'd3;

   // Request held at the top and broadcast to every cell during a scan.
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [KEY_W-1:0]  key;
      logic [DEST_W-1:0] dest;
   } scan_req_type;

   // Token that walks down the chain, one cell per cycle.
   typedef struct packed {
      logic              active;
      logic              matched;
      logic              free_found;
      logic [DEST_W-1:0] found_dest;
   } token_type;

   // Write of a new entry once the scan has found a free slot.
   typedef struct packed {
      logic              en;
      logic [KEY_W-1:0]  key;
      logic [DEST_W-1:0] dest;
   } fill_type;

endpackage

`default_nettype wire

>>> rtl/nft_cell.sv
`default_nettype none

module nft_cell
   import nft_pkg::*;
#(
   parameter int IDX_W    = 7,
   parameter int CELL_IDX = 0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire scan_req_type     scan_req,
   input  wire fill_type         fill,
   input  wire logic [IDX_W-1:0] fill_idx,
   input  wire token_type        tok_in,
   input  wire logic [IDX_W-1:0] free_idx_in,
   output token_type             tok_out,
   output logic      [IDX_W-1:0] free_idx_out
);

   logic              valid_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [DEST_W-1:0] dest_ff;
   token_type         tok_ff;
   logic [IDX_W-1:0]  free_idx_ff;

   logic              hit_here;
   logic              free_here;
   logic              fill_here;
   token_type         tok_in_next;
   logic [IDX_W-1:0]  free_idx_in_next;

   // Only the first valid matching entry acts; the first free slot is noted.
   always_comb begin
      hit_here  = tok_in.active && valid_ff && !tok_in.matched && (key_ff == scan_req.key);
      free_here = tok_in.active && !valid_ff && !tok_in.free_found;
      fill_here = fill.en && (fill_idx == IDX_W'(CELL_IDX));

      tok_in_next            = tok_in;
      tok_in_next.matched    = tok_in.matched || hit_here;
      tok_in_next.free_found = tok_in.free_found || free_here;
      if (hit_here && scan_req.op == OP_LOOKUP) begin
         tok_in_next.found_dest = dest_ff;
      end
      free_idx_in_next = free_here ? IDX_W'(CELL_IDX) : free_idx_in;
   end

   // Entry storage and the token register towards the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff      <= tok_in_next;
         free_idx_ff <= free_idx_in_next;
         if (fill_here) begin
            valid_ff <= 1'b1;
            key_ff   <= fill.key;
            dest_ff  <= fill.dest;
         end else if (hit_here && scan_req.op == OP_INSERT) begin
            dest_ff <= scan_req.dest;
         end else if (hit_here && scan_req.op == OP_REMOVE) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign tok_out      = tok_ff;
   assign free_idx_out = free_idx_ff;

endmodule

`default_nettype wire

>>> rtl/nat_flow_table.sv
`default_nettype none

// NAT flow table: TABLE_DEPTH entries map a client key (address and port) to an
// original destination address. Each request inserts or updates, looks up, or
// removes one key and yields exactly one response. The entries sit in a chain of
// cells and a token carrying the scan state walks the chain one cell per cycle,
// so the response is loaded once the token has left the last cell and the
// response register is free. A new request is taken only after the previous
// response has been loaded, so the time a request holds the table is set by the
// length of the chain; a response held back by rsp_tready stalls the next one in
// S_DONE. One request is in the table at a time. Insert first updates an entry
// with the same key, otherwise it fills the lowest free slot, or is dropped with
// status "full". All entries are invalid after reset; no clearing pass is needed.

module nat_flow_table
   import nft_pkg::*;
#(
   parameter int TABLE_DEPTH = 128
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // op[1:0], client_addr[33:2], src_port[49:34], dest_addr[81:50], zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // hit[0], found_dest[32:1], status[34:33], zero pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic                  start_ff, start_in;
   scan_req_type          scan_req_ff, scan_req_in;
   token_type             hold_tok_ff, hold_tok_in;
   logic [IDX_W-1:0]      hold_idx_ff, hold_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [DEST_W-1:0]     rsp_found_ff, rsp_found_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   token_type             tok   [TABLE_DEPTH+1];
   logic [IDX_W-1:0]      fidx  [TABLE_DEPTH+1];
   fill_type              fill;
   logic                  req_accept;
   logic                  rsp_free;

   // Input handshake and response handshake.
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Token injected into the first cell in the cycle after the request is taken.
   always_comb begin
      tok[0]            = '0;
      tok[0].active     = start_ff;
      fidx[0]           = '0;
   end

   // Chain of entry cells.
   for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      nft_cell #(
         .IDX_W    (IDX_W),
         .CELL_IDX (gi)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .scan_req     (scan_req_ff),
         .fill         (fill),
         .fill_idx     (hold_idx_ff),
         .tok_in       (tok[gi]),
         .free_idx_in  (fidx[gi]),
         .tok_out      (tok[gi+1]),
         .free_idx_out (fidx[gi+1])
      );
   end

   // A new key is written into the free slot when the response is loaded.
   always_comb begin
      fill.en   = (state_ff == S_DONE) && rsp_free && (scan_req_ff.op == OP_INSERT) &&
                  !hold_tok_ff.matched && hold_tok_ff.free_found;
      fill.key  = scan_req_ff.key;
      fill.dest = scan_req_ff.dest;
   end

   // Sequencer and response register: next values.
   always_comb begin
      state_in      = state_ff;
      start_in      = 1'b0;
      scan_req_in   = scan_req_ff;
      hold_tok_in   = hold_tok_ff;
      hold_idx_in   = hold_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               scan_req_in.op   = req_tdata[1:0];
               scan_req_in.key  = {req_tdata[33:2], req_tdata[49:34]};
               scan_req_in.dest = req_tdata[81:50];
               start_in         = 1'b1;
               state_in         = S_SCAN;
            end
         end
         S_SCAN: begin
            if (tok[TABLE_DEPTH].active) begin
               hold_tok_in = tok[TABLE_DEPTH];
               hold_idx_in = fidx[TABLE_DEPTH];
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = 1'b0;
               rsp_found_in  = '0;
               rsp_status_in = ST_DONE;
               case (scan_req_ff.op)
                  OP_INSERT: begin
                     if (hold_tok_ff.matched) begin
                        rsp_hit_in    = 1'b1;
                        rsp_status_in = ST_UPDATED;
                     end else if (hold_tok_ff.free_found) begin
                        rsp_status_in = ST_INSERTED;
                     end else begin
                        rsp_status_in = ST_FULL;
                     end
                  end
                  OP_LOOKUP: begin
                     rsp_hit_in = hold_tok_ff.matched;
                     if (hold_tok_ff.matched) begin
                        rsp_found_in = hold_tok_ff.found_dest;
                     end
                  end
                  OP_REMOVE: begin
                     rsp_hit_in = hold_tok_ff.matched;
                  end
                  default: begin
                     rsp_hit_in = 1'b0;
                  end
               endcase
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer state and registered response.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         start_ff      <= start_in;
         rsp_valid_ff  <= rsp_valid_in;
         scan_req_ff   <= scan_req_in;
         hold_tok_ff   <= hold_tok_in;
         hold_idx_ff   <= hold_idx_in;
         rsp_hit_ff    <= rsp_hit_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   always_comb begin
      rsp_tdata          = '0;
      rsp_tdata[0]       = rsp_hit_ff;
      rsp_tdata[32:1]    = rsp_found_ff;
      rsp_tdata[34:33]   = rsp_status_ff;
   end

   // Once a request is taken the table stays busy for the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a scan was under way");

   // The token leaves the chain only while a scan is in progress.
   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok[TABLE_DEPTH].active |-> state_ff == S_SCAN)
      else $error("scan token arrived outside a scan");

   // A dropped insert never reports a hit.
   a_full_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[34:33] == ST_FULL |-> !rsp_tdata[0])
      else $error("full status reported with a hit");

   // A destination is only returned with a hit.
   a_found_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[32:1] == '0)
      else $error("destination returned without a hit");

endmodule

`default_nettype wire
